@@ rtl/cosine_similarity_loss_assert.svh @@
// ----------------------------------------------------------------------------
// Cosine similarity loss assertion macros
// Shared property templates for the block's checker, clocked on clk_i and
// disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef COSINE_SIMILARITY_LOSS_ASSERT_SVH
`define COSINE_SIMILARITY_LOSS_ASSERT_SVH

// Condition holds in the same cycle as the trigger.
`define CSL_ASSERT_SAME(name, trig, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (cond)) \
    else $error(msg);

// Condition holds in the cycle after the trigger.
`define CSL_ASSERT_NEXT(name, trig, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error(msg);

`endif

@@ rtl/csl_pkg.sv @@
// ----------------------------------------------------------------------------
// Cosine similarity loss package
// Widths, constants and shared types of the cosine similarity loss block.
// ----------------------------------------------------------------------------
package csl_pkg;

  localparam int DataWidth   = 16;
  localparam int MaxElements = 65536;
  localparam int CountWidth  = $clog2(MaxElements + 1);
  localparam int ProdWidth   = 2 * DataWidth;
  localparam int SqWidth     = ProdWidth - 1;
  localparam int AccWidth    = 48;
  localparam int RadWidth    = 40;
  localparam int RootWidth   = RadWidth / 2;
  localparam int DenWidth    = 2 * RootWidth;
  localparam int LossWidth   = 16;
  localparam int FracBits    = 14;
  localparam int QuotWidth   = FracBits + 1;
  localparam int NumWidth    = DenWidth + QuotWidth;
  localparam int QueueDepth  = 2;
  localparam int QPtrWidth   = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntWidth   = $clog2(QueueDepth + 1);

  localparam logic [LossWidth-1:0] OneQ14  = LossWidth'(1 << FracBits);
  localparam logic [LossWidth-1:0] LossMax = LossWidth'(2 << FracBits);

  typedef logic [CountWidth-1:0] count_t;
  typedef logic [QPtrWidth-1:0]  qptr_t;
  typedef logic [QCntWidth-1:0]  qcnt_t;

  // Accumulated sums of one finished vector pair.
  typedef struct packed {
    logic signed [AccWidth-1:0] dot;
    logic [AccWidth-1:0]        pp;
    logic [AccWidth-1:0]        tt;
    logic                       sat;
  } sums_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

@@ rtl/csl_if.sv @@
// ----------------------------------------------------------------------------
// Cosine similarity loss channels
// Valid/ready interfaces for element pairs in and loss results out.
// ----------------------------------------------------------------------------
interface csl_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [csl_pkg::DataWidth-1:0] prediction;
  logic signed [csl_pkg::DataWidth-1:0] target;
  logic                                 last_element;

  modport source (output valid, prediction, target, last_element, input ready);
  modport sink   (input valid, prediction, target, last_element, output ready);
endinterface

interface csl_out_if;
  logic                             valid;
  logic                             ready;
  logic [csl_pkg::LossWidth-1:0]    loss;
  logic                             zero_norm;
  logic                             overflow;

  modport source (output valid, loss, zero_norm, overflow, input ready);
  modport sink   (input valid, loss, zero_norm, overflow, output ready);
endinterface

@@ rtl/csl_front.sv @@
// ----------------------------------------------------------------------------
// Cosine similarity loss front end
// Takes one element pair per cycle while no closing element waits for queue
// room, accumulates the three products saturating and queues vector sums.
// ----------------------------------------------------------------------------
module csl_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  csl_in_if.sink             in_i,
  input  csl_pkg::q_status_t q_status_i,
  output logic               push_o,
  output csl_pkg::sums_t     sums_o
);

  localparam int DW = csl_pkg::DataWidth;
  localparam int PW = csl_pkg::ProdWidth;
  localparam int SW = csl_pkg::SqWidth;
  localparam int AW = csl_pkg::AccWidth;

  logic signed [PW-1:0] pred_x, tgt_x;
  logic signed [PW-1:0] prod_pt, prod_pp, prod_tt;
  logic                 in_accept, s1_fire, can_acc;

  // Product stage.
  logic                 s1_valid_q, s1_last_q, s1_acc_q;
  logic signed [PW-1:0] s1_dp_q;
  logic [SW-1:0]        s1_pp_q, s1_tt_q;
  csl_pkg::count_t      count_q, count_d;

  // Accumulator stage.
  csl_pkg::sums_t       acc_q, acc_nxt;
  logic signed [AW:0]   dot_wide;
  logic [AW:0]          pp_wide, tt_wide;

  assign pred_x = {{(PW-DW){in_i.prediction[DW-1]}}, in_i.prediction};
  assign tgt_x  = {{(PW-DW){in_i.target[DW-1]}}, in_i.target};
  assign prod_pt = pred_x * tgt_x;
  assign prod_pp = pred_x * pred_x;
  assign prod_tt = tgt_x * tgt_x;

  assign in_accept = in_i.valid && in_i.ready;
  // A closing element waits here until the queue has room for its sums.
  assign s1_fire   = s1_valid_q && !(s1_last_q && q_status_i.full);
  assign in_i.ready = !s1_valid_q || s1_fire;
  assign can_acc   = count_q < csl_pkg::count_t'(csl_pkg::MaxElements);

  always_comb begin
    count_d = count_q;
    if (in_accept) begin
      if (in_i.last_element) begin
        count_d = '0;
      end else if (can_acc) begin
        count_d = count_q + csl_pkg::count_t'(1);
      end
    end
  end

  assign dot_wide = {acc_q.dot[AW-1], acc_q.dot} + {{(AW+1-PW){s1_dp_q[PW-1]}}, s1_dp_q};
  assign pp_wide  = {1'b0, acc_q.pp} + {{(AW+1-SW){1'b0}}, s1_pp_q};
  assign tt_wide  = {1'b0, acc_q.tt} + {{(AW+1-SW){1'b0}}, s1_tt_q};

  always_comb begin
    acc_nxt = acc_q;
    if (s1_acc_q) begin
      if (dot_wide[AW] != dot_wide[AW-1]) begin
        acc_nxt.dot = dot_wide[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
        acc_nxt.sat = 1'b1;
      end else begin
        acc_nxt.dot = dot_wide[AW-1:0];
      end
      if (pp_wide[AW]) begin
        acc_nxt.pp  = '1;
        acc_nxt.sat = 1'b1;
      end else begin
        acc_nxt.pp = pp_wide[AW-1:0];
      end
      if (tt_wide[AW]) begin
        acc_nxt.tt  = '1;
        acc_nxt.sat = 1'b1;
      end else begin
        acc_nxt.tt = tt_wide[AW-1:0];
      end
    end else begin
      // Element beyond the length limit is dropped.
      acc_nxt.sat = 1'b1;
    end
  end

  assign push_o = s1_fire && s1_last_q;
  assign sums_o = acc_nxt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_last_q  <= 1'b0;
      s1_acc_q   <= 1'b0;
      count_q    <= '0;
      acc_q      <= '0;
    end else begin
      count_q <= count_d;
      if (in_accept) begin
        s1_valid_q <= 1'b1;
        s1_last_q  <= in_i.last_element;
        s1_acc_q   <= can_acc;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        acc_q <= s1_last_q ? '0 : acc_nxt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_dp_q <= prod_pt;
      s1_pp_q <= prod_pp[SW-1:0];
      s1_tt_q <= prod_tt[SW-1:0];
    end
  end

endmodule

@@ rtl/csl_fifo.sv @@
// ----------------------------------------------------------------------------
// Cosine similarity loss sum queue
// Short first-in first-out queue of finished vector sums between the
// accumulators and the normalizing back end.
// ----------------------------------------------------------------------------
module csl_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  csl_pkg::sums_t     sums_i,
  input  logic               pop_i,
  output csl_pkg::sums_t     sums_o,
  output csl_pkg::q_status_t status_o
);

  csl_pkg::sums_t entries_q [csl_pkg::QueueDepth];
  csl_pkg::qptr_t wr_ptr_q, rd_ptr_q;
  csl_pkg::qcnt_t cnt_q;
  logic           do_push, do_pop;

  function automatic csl_pkg::qptr_t ptr_inc(input csl_pkg::qptr_t p);
    if (p == csl_pkg::qptr_t'(csl_pkg::QueueDepth - 1)) begin
      return '0;
    end
    return p + csl_pkg::qptr_t'(1);
  endfunction

  assign status_o.full  = cnt_q == csl_pkg::qcnt_t'(csl_pkg::QueueDepth);
  assign status_o.empty = cnt_q == '0;
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign sums_o  = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + csl_pkg::qcnt_t'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - csl_pkg::qcnt_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= sums_i;
    end
  end

endmodule

@@ rtl/csl_back.sv @@
// ----------------------------------------------------------------------------
// Cosine similarity loss back end
// Sequencer that takes one vector's sums, forms both square roots bit by
// bit, multiplies them and divides the dot product one quotient bit a cycle.
// ----------------------------------------------------------------------------
module csl_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  csl_pkg::q_status_t q_status_i,
  input  csl_pkg::sums_t     sums_i,
  output logic               pop_o,
  csl_out_if.source          out_o
);

  localparam int AW  = csl_pkg::AccWidth;
  localparam int RW  = csl_pkg::RadWidth;
  localparam int QW  = csl_pkg::RootWidth;
  localparam int MW  = QW + 2;
  localparam int DW  = csl_pkg::DenWidth;
  localparam int NW  = csl_pkg::NumWidth;
  localparam int VW  = csl_pkg::QuotWidth;
  localparam int LW  = csl_pkg::LossWidth;
  localparam int FB  = csl_pkg::FracBits;
  localparam int MaxHalf = (AW - RW) / 2;
  localparam int StepWidth = $clog2(QW);

  typedef enum logic [5:0] {
    StIdle    = 6'b000001,
    StSqrt    = 6'b000010,
    StMul     = 6'b000100,
    StDivInit = 6'b001000,
    StDiv     = 6'b010000,
    StDone    = 6'b100000
  } state_e;

  typedef struct packed {
    logic [MW-1:0] rem;
    logic [QW-1:0] root;
  } sq_t;

  state_e               state_q, state_d;
  logic [StepWidth-1:0] step_q, step_d;
  logic [RW-1:0]        rad_p_q, rad_t_q, rad_p_d, rad_t_d;
  sq_t                  sq_p_q, sq_t_q, sq_p_d, sq_t_d;
  logic [AW-1:0]        mag_q, mag_d;
  logic                 neg_q, neg_d;
  logic [DW-1:0]        den_q, den_d;
  logic [NW-1:0]        num_q, num_d, dsh_q, dsh_d;
  logic [VW-1:0]        quot_q, quot_d;
  logic [LW-1:0]        res_loss_q, res_loss_d;
  logic                 res_zn_q, res_zn_d, res_ovf_q, res_ovf_d;
  logic                 out_valid_q, out_load;
  logic [LW-1:0]        out_loss_q;
  logic                 out_zn_q, out_ovf_q;

  logic [2:0]           half_p, half_t;
  logic [3:0]           half_sum;
  logic [AW-1:0]        pp_sh, tt_sh, dot_abs;
  logic [DW-1:0]        mag_clamp;
  logic                 div_ge;
  logic [VW-1:0]        quot_fin;

  // Smallest h such that n >> 2h lies below 2^RadWidth.
  function automatic logic [2:0] norm_half(input logic [AW-1:0] n);
    logic [2:0] h;
    h = '0;
    for (int k = 1; k <= MaxHalf; k++) begin
      if ((n >> (RW + 2 * (k - 1))) != '0) begin
        h = 3'(k);
      end
    end
    return h;
  endfunction

  // One step of the digit-by-digit square root: brings down two radicand bits.
  function automatic sq_t sqrt_step(input sq_t cur, input logic [1:0] bits2);
    logic [MW-1:0] r_sh, trial;
    sq_t           nxt;
    r_sh  = {cur.rem[MW-3:0], bits2};
    trial = {cur.root, 2'b01};
    if (r_sh >= trial) begin
      nxt.rem  = r_sh - trial;
      nxt.root = {cur.root[QW-2:0], 1'b1};
    end else begin
      nxt.rem  = r_sh;
      nxt.root = {cur.root[QW-2:0], 1'b0};
    end
    return nxt;
  endfunction

  assign half_p   = norm_half(sums_i.pp);
  assign half_t   = norm_half(sums_i.tt);
  assign half_sum = {1'b0, half_p} + {1'b0, half_t};
  assign pp_sh    = sums_i.pp >> {half_p, 1'b0};
  assign tt_sh    = sums_i.tt >> {half_t, 1'b0};
  assign dot_abs  = sums_i.dot[AW-1] ? AW'(-sums_i.dot) : AW'(sums_i.dot);

  assign mag_clamp = (mag_q > {{(AW-DW){1'b0}}, den_q}) ? den_q : mag_q[DW-1:0];
  assign div_ge    = num_q >= dsh_q;
  assign quot_fin  = {quot_q[VW-2:0], div_ge};

  assign pop_o    = (state_q == StIdle) && !q_status_i.empty;
  assign out_load = (state_q == StDone) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    rad_p_d    = rad_p_q;
    rad_t_d    = rad_t_q;
    sq_p_d     = sq_p_q;
    sq_t_d     = sq_t_q;
    mag_d      = mag_q;
    neg_d      = neg_q;
    den_d      = den_q;
    num_d      = num_q;
    dsh_d      = dsh_q;
    quot_d     = quot_q;
    res_loss_d = res_loss_q;
    res_zn_d   = res_zn_q;
    res_ovf_d  = res_ovf_q;
    unique case (state_q)
      StIdle: begin
        if (!q_status_i.empty) begin
          rad_p_d   = pp_sh[RW-1:0];
          rad_t_d   = tt_sh[RW-1:0];
          sq_p_d    = '0;
          sq_t_d    = '0;
          mag_d     = dot_abs >> half_sum;
          neg_d     = sums_i.dot[AW-1];
          step_d    = StepWidth'(QW - 1);
          res_ovf_d = sums_i.sat;
          if (sums_i.pp == '0 || sums_i.tt == '0) begin
            res_loss_d = csl_pkg::OneQ14;
            res_zn_d   = 1'b1;
            state_d    = StDone;
          end else begin
            res_zn_d = 1'b0;
            state_d  = StSqrt;
          end
        end
      end
      StSqrt: begin
        sq_p_d  = sqrt_step(sq_p_q, rad_p_q[RW-1 -: 2]);
        sq_t_d  = sqrt_step(sq_t_q, rad_t_q[RW-1 -: 2]);
        rad_p_d = {rad_p_q[RW-3:0], 2'b00};
        rad_t_d = {rad_t_q[RW-3:0], 2'b00};
        step_d  = step_q - StepWidth'(1);
        if (step_q == '0) begin
          state_d = StMul;
        end
      end
      StMul: begin
        den_d   = sq_p_q.root * sq_t_q.root;
        state_d = StDivInit;
      end
      StDivInit: begin
        // Rounded quotient: (mag * 2^14 + den/2) / den, at most 2^14.
        num_d   = {1'b0, mag_clamp, {FB{1'b0}}} + {{(NW-DW){1'b0}}, den_q >> 1};
        dsh_d   = {1'b0, den_q, {FB{1'b0}}};
        quot_d  = '0;
        step_d  = StepWidth'(FB);
        state_d = StDiv;
      end
      StDiv: begin
        if (div_ge) begin
          num_d = num_q - dsh_q;
        end
        dsh_d  = dsh_q >> 1;
        quot_d = quot_fin;
        step_d = step_q - StepWidth'(1);
        if (step_q == '0) begin
          res_loss_d = neg_q ? csl_pkg::OneQ14 + {1'b0, quot_fin}
                             : csl_pkg::OneQ14 - {1'b0, quot_fin};
          state_d    = StDone;
        end
      end
      StDone: begin
        if (out_load) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    step_q     <= step_d;
    rad_p_q    <= rad_p_d;
    rad_t_q    <= rad_t_d;
    sq_p_q     <= sq_p_d;
    sq_t_q     <= sq_t_d;
    mag_q      <= mag_d;
    neg_q      <= neg_d;
    den_q      <= den_d;
    num_q      <= num_d;
    dsh_q      <= dsh_d;
    quot_q     <= quot_d;
    res_loss_q <= res_loss_d;
    res_zn_q   <= res_zn_d;
    res_ovf_q  <= res_ovf_d;
    if (out_load) begin
      out_loss_q <= res_loss_q;
      out_zn_q   <= res_zn_q;
      out_ovf_q  <= res_ovf_q;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.loss      = out_loss_q;
  assign out_o.zero_norm = out_zn_q;
  assign out_o.overflow  = out_ovf_q;

endmodule

@@ rtl/cosine_similarity_loss.sv @@
// ----------------------------------------------------------------------------
// Cosine similarity loss
// Streams a prediction/target vector pair and returns 1 - cos(p, t).
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one element pair per transaction (signed Q4.12 each) and a
//   last_element mark that closes the vector. out_o returns one transaction
//   per closed vector: loss as unsigned Q2.14 (0 to 2.0), zero_norm when a
//   norm was zero (loss is then 1.0), and overflow when elements past the
//   length limit were dropped or an accumulator saturated.
//   Throughput: the accumulators take one element per cycle while no closing
//   element waits on a full sum queue. The back end works on one vector at a
//   time: a pop, 20 square-root steps, a multiply, a divider setup, 15
//   quotient bits and a hand-off; the two-entry sum queue holds up to two
//   pending vectors, after which the closing element of a further vector
//   waits. A zero norm skips the square roots, the multiply and the divider.
//   Reset clears the accumulators, the element count, the queue and the
//   output valid flag. A stalled receiver holds the result in the output
//   register; the back end finishes the vector it holds and then waits,
//   and the accumulators keep taking elements until a closing element
//   meets a full sum queue.
// ----------------------------------------------------------------------------
module cosine_similarity_loss (
  input  logic      clk_i,
  input  logic      rst_ni,
  csl_in_if.sink    in_i,
  csl_out_if.source out_o
);

  logic               push, pop;
  csl_pkg::sums_t     push_sums, pop_sums;
  csl_pkg::q_status_t q_status;

  csl_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .q_status_i (q_status),
    .push_o     (push),
    .sums_o     (push_sums)
  );

  csl_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .sums_i   (push_sums),
    .pop_i    (pop),
    .sums_o   (pop_sums),
    .status_o (q_status)
  );

  csl_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_status_i (q_status),
    .sums_i     (pop_sums),
    .pop_o      (pop),
    .out_o      (out_o)
  );

endmodule

@@ rtl/csl_checker.sv @@
// ----------------------------------------------------------------------------
// Cosine similarity loss checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "cosine_similarity_loss_assert.svh"

module csl_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [csl_pkg::LossWidth-1:0] loss_i,
  input logic                          zero_norm_i,
  input logic                          overflow_i
);

  // A result waiting for the receiver must not change.
  `CSL_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(loss_i) && $stable(zero_norm_i) && $stable(overflow_i), "result changed while stalled")

  `CSL_ASSERT_SAME(a_zero_norm_loss, out_valid_i && zero_norm_i, loss_i == csl_pkg::OneQ14, "zero-norm result must carry a loss of 1.0")

  `CSL_ASSERT_SAME(a_loss_range, out_valid_i, loss_i <= csl_pkg::LossMax, "loss above 2.0")

endmodule

bind cosine_similarity_loss csl_checker u_csl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .loss_i      (out_o.loss),
  .zero_norm_i (out_o.zero_norm),
  .overflow_i  (out_o.overflow)
);
